// File: hw/rtl/bss_pkg.sv
// Shared types and constants for the breaker switch supervisor.
// No dependencies; used by bss_step and breaker_switch_supervisor.
`timescale 1ns / 1ps

package bss_pkg;

  // supervisor state codes
  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_OFF    = 3'd1;
  localparam logic [2:0] ST_GO_ON  = 3'd2;
  localparam logic [2:0] ST_ON     = 3'd3;
  localparam logic [2:0] ST_GO_OFF = 3'd4;
  localparam logic [2:0] ST_FAILED = 3'd5;
  localparam logic [2:0] ST_NONE   = 3'h7;  // previous mode before the first tick

  // command codes
  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  // indication codes
  localparam logic [1:0] IND_UNDEF = 2'd0;
  localparam logic [1:0] IND_ON    = 2'd1;
  localparam logic [1:0] IND_OFF   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_CLOSE_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_OPEN_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_PULSE_LENGTH  = 2'd2;
  localparam logic [1:0] REG_INIT_WAIT     = 2'd3;

  localparam int CFG_W = 16;

  localparam logic [CFG_W-1:0] CLOSE_TIMEOUT_RST = 16'd100;
  localparam logic [CFG_W-1:0] OPEN_TIMEOUT_RST  = 16'd100;
  localparam logic [CFG_W-1:0] PULSE_LENGTH_RST  = 16'd500;
  localparam logic [CFG_W-1:0] INIT_WAIT_RST     = 16'd200;

  typedef struct packed {
    logic [CFG_W-1:0] close_timeout;
    logic [CFG_W-1:0] open_timeout;
    logic [CFG_W-1:0] pulse_length;
    logic [CFG_W-1:0] init_wait;
  } cfg_t;

  typedef struct packed {
    logic       contact_on;
    logic       contact_off;
    logic [1:0] command;
    logic       fail_clear;
  } tick_in_t;

  // supervisor state, apart from the tick counter
  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] prev_mode;
    logic [1:0] prev_cmd;
    logic       coil_close;
    logic       coil_open;
    logic       hold_cl;
    logic       hold_op;
    logic [1:0] shown;
    logic       sw_fail;
    logic       bk_fault;
  } sup_state_t;

  typedef struct packed {
    logic       close_pulse;
    logic       open_pulse;
    logic       hold_closed;
    logic       hold_open;
    logic [1:0] indication;
    logic       switch_failure;
    logic       contact_fault;
    logic [2:0] current_state;
    logic       state_entered;
  } tick_out_t;

endpackage

// File: hw/rtl/bss_step.sv
// Next-state and result logic for one tick of the breaker supervisor.
// Depends on bss_pkg.
`timescale 1ns / 1ps

module bss_step #(
  parameter int COUNT_WIDTH = 16
) (
  input  bss_pkg::cfg_t        cfg,
  input  bss_pkg::tick_in_t    tick,
  input  bss_pkg::sup_state_t  st,
  input  logic [COUNT_WIDTH-1:0] count,
  output bss_pkg::sup_state_t  st_next,
  output logic [COUNT_WIDTH-1:0] count_next,
  output bss_pkg::tick_out_t   res
);

  localparam int CMP_W = (COUNT_WIDTH > bss_pkg::CFG_W) ? COUNT_WIDTH : bss_pkg::CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [CMP_W-1:0] CNT_MAX_X = CMP_W'(CNT_MAX);

  function automatic logic [COUNT_WIDTH-1:0] cnt_inc(input logic [COUNT_WIDTH-1:0] c);
    cnt_inc = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] cnt_cap(input logic [bss_pkg::CFG_W-1:0] v);
    logic [CMP_W-1:0] vx;
    vx = CMP_W'(v);
    cnt_cap = (vx > CNT_MAX_X) ? CNT_MAX : COUNT_WIDTH'(vx);
  endfunction

  function automatic logic cnt_gt(input logic [COUNT_WIDTH-1:0] c,
                                  input logic [bss_pkg::CFG_W-1:0] v);
    cnt_gt = CMP_W'(c) > CMP_W'(v);
  endfunction

  always_comb begin
    bss_pkg::sup_state_t s;
    logic [COUNT_WIDTH-1:0] c;
    logic entered;
    logic on, off;

    s       = st;
    c       = count;
    on      = tick.contact_on;
    off     = tick.contact_off;

    if (on && !off) s.shown = bss_pkg::IND_ON;
    if (!on && off) s.shown = bss_pkg::IND_OFF;
    if (tick.fail_clear) s.sw_fail = 1'b0;

    entered     = (st.prev_mode != st.mode);
    s.prev_mode = st.mode;

    case (st.mode)
      bss_pkg::ST_INIT: begin
        if (entered) c = '0;
        s.coil_close = 1'b0;
        s.coil_open  = 1'b0;
        s.hold_cl    = 1'b0;
        s.hold_op    = 1'b0;
        s.sw_fail    = 1'b0;
        c = cnt_inc(c);
        if (cnt_gt(c, cfg.init_wait)) begin
          if (!on && off) s.mode = bss_pkg::ST_OFF;
          if (on && !off) s.mode = bss_pkg::ST_ON;
          if (on == off)  s.mode = bss_pkg::ST_FAILED;
        end
      end
      bss_pkg::ST_OFF: begin
        s.hold_cl = 1'b0;
        s.hold_op = 1'b1;
        if (tick.command == bss_pkg::CMD_ON) s.mode = bss_pkg::ST_GO_ON;
        if (tick.command == bss_pkg::CMD_OFF && st.prev_cmd != bss_pkg::CMD_OFF)
          s.mode = bss_pkg::ST_GO_OFF;
        if (!off && on) begin
          s.mode    = bss_pkg::ST_ON;
          s.sw_fail = 1'b1;
        end
        if (on == off) begin
          s.shown    = bss_pkg::IND_UNDEF;
          s.bk_fault = 1'b1;
        end else begin
          s.bk_fault = 1'b0;
        end
      end
      bss_pkg::ST_GO_ON: begin
        if (entered) begin
          s.coil_close = 1'b1;
          s.coil_open  = 1'b0;
          c = '0;
        end
        s.hold_cl = 1'b1;
        s.hold_op = 1'b0;
        if (tick.command == bss_pkg::CMD_OFF) s.mode = bss_pkg::ST_GO_OFF;
        // pulse limit is checked on the count before this tick's increment
        if (cnt_gt(c, cfg.pulse_length)) s.coil_close = 1'b0;
        c = cnt_inc(c);
        if (CMP_W'(c) >= CMP_W'(cfg.close_timeout)) begin
          c = cnt_cap(cfg.close_timeout);
          s.coil_close = 1'b0;
          s.mode = (on && !off) ? bss_pkg::ST_ON : bss_pkg::ST_FAILED;
        end
      end
      bss_pkg::ST_ON: begin
        s.hold_cl = 1'b1;
        s.hold_op = 1'b0;
        if (tick.command == bss_pkg::CMD_OFF) s.mode = bss_pkg::ST_GO_OFF;
        if (tick.command == bss_pkg::CMD_ON && st.prev_cmd != bss_pkg::CMD_ON)
          s.mode = bss_pkg::ST_GO_ON;
        if (off && !on) begin
          s.mode    = bss_pkg::ST_OFF;
          s.sw_fail = 1'b1;
        end
        if (on == off) begin
          s.shown    = bss_pkg::IND_UNDEF;
          s.bk_fault = 1'b1;
        end else begin
          s.bk_fault = 1'b0;
        end
      end
      bss_pkg::ST_GO_OFF: begin
        if (entered) begin
          s.coil_close = 1'b0;
          s.coil_open  = 1'b1;
          c = '0;
        end
        s.hold_cl = 1'b0;
        s.hold_op = 1'b1;
        c = cnt_inc(c);
        if (cnt_gt(c, cfg.pulse_length)) s.coil_open = 1'b0;
        if (CMP_W'(c) >= CMP_W'(cfg.open_timeout)) begin
          c = cnt_cap(cfg.open_timeout);
          s.coil_open = 1'b0;
          s.mode = (off && !on) ? bss_pkg::ST_OFF : bss_pkg::ST_FAILED;
        end
      end
      bss_pkg::ST_FAILED: begin
        if (entered) begin
          s.coil_close = 1'b0;
          s.coil_open  = 1'b1;
          c = '0;
        end
        c = cnt_inc(c);
        if (cnt_gt(c, cfg.pulse_length)) s.coil_open = 1'b0;
        s.hold_cl = 1'b0;
        s.hold_op = 1'b1;
        s.sw_fail = 1'b1;
        if (tick.fail_clear) begin
          s.coil_open = 1'b0;
          s.sw_fail   = 1'b0;
          s.mode      = bss_pkg::ST_OFF;
        end
      end
      default: begin
        s.mode = bss_pkg::ST_FAILED;
      end
    endcase

    s.prev_cmd = tick.command;

    st_next    = s;
    count_next = c;

    res.close_pulse    = s.coil_close;
    res.open_pulse     = s.coil_open;
    res.hold_closed    = s.hold_cl;
    res.hold_open      = s.hold_op;
    res.indication     = s.shown;
    res.switch_failure = s.sw_fail;
    res.contact_fault  = s.bk_fault;
    res.current_state  = st.mode;
    res.state_entered  = entered;
  end

endmodule

// File: hw/rtl/breaker_switch_supervisor.sv
// Breaker switch supervisor top level: config registers, beat registers, state.
// Depends on bss_pkg and bss_step.
`timescale 1ns / 1ps

// One input beat is one millisecond tick carrying both auxiliary contacts, the
// on/off command and the failure clear; each beat yields exactly one result beat.
// The block takes one beat per clock cycle while the output is not stalled. A beat
// accepted on s_axis sits in the input register until one pass of the supervisor
// logic loads its result into the result register, from which it is offered on
// m_axis. A stalled output holds the input beat and drops s_axis_tready. The
// supervisor state updates in the same cycle the result is registered, so the
// next beat sees it without a bubble.
// Configuration writes (index 0 close_timeout, 1 open_timeout, 2 pulse_length,
// 3 init_wait) are always accepted and should be issued only while no tick is
// in flight.
module breaker_switch_supervisor #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] contact_on, [1] contact_off, [3:2] command, [4] fail_clear, [7:5] zero
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] close_pulse, [1] open_pulse, [2] hold_closed, [3] hold_open,
  // [5:4] indication, [6] switch_failure, [7] contact_fault,
  // [10:8] current_state, [11] state_entered, [15:12] zero
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  bss_pkg::cfg_t       cfg;
  bss_pkg::tick_in_t   in_beat;
  logic                in_valid;
  bss_pkg::sup_state_t st, st_next;
  logic [COUNT_WIDTH-1:0] count, count_next;
  bss_pkg::tick_out_t  res, out_beat;
  logic                out_valid;
  logic                advance;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_beat.state_entered, out_beat.current_state,
                          out_beat.contact_fault, out_beat.switch_failure,
                          out_beat.indication, out_beat.hold_open, out_beat.hold_closed,
                          out_beat.open_pulse, out_beat.close_pulse};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.close_timeout <= bss_pkg::CLOSE_TIMEOUT_RST;
      cfg.open_timeout  <= bss_pkg::OPEN_TIMEOUT_RST;
      cfg.pulse_length  <= bss_pkg::PULSE_LENGTH_RST;
      cfg.init_wait     <= bss_pkg::INIT_WAIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        bss_pkg::REG_CLOSE_TIMEOUT: cfg.close_timeout <= cfg_data;
        bss_pkg::REG_OPEN_TIMEOUT:  cfg.open_timeout  <= cfg_data;
        bss_pkg::REG_PULSE_LENGTH:  cfg.pulse_length  <= cfg_data;
        bss_pkg::REG_INIT_WAIT:     cfg.init_wait     <= cfg_data;
        default: ;
      endcase
    end
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_beat.contact_on  <= s_axis_tdata[0];
      in_beat.contact_off <= s_axis_tdata[1];
      in_beat.command     <= s_axis_tdata[3:2];
      in_beat.fail_clear  <= s_axis_tdata[4];
    end
  end

  bss_step #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .cfg        (cfg),
    .tick       (in_beat),
    .st         (st),
    .count      (count),
    .st_next    (st_next),
    .count_next (count_next),
    .res        (res)
  );

  // supervisor state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode       <= bss_pkg::ST_INIT;
      st.prev_mode  <= bss_pkg::ST_NONE;
      st.prev_cmd   <= bss_pkg::CMD_NONE;
      st.coil_close <= 1'b0;
      st.coil_open  <= 1'b0;
      st.hold_cl    <= 1'b0;
      st.hold_op    <= 1'b0;
      st.shown      <= bss_pkg::IND_UNDEF;
      st.sw_fail    <= 1'b0;
      st.bk_fault   <= 1'b0;
      count         <= '0;
      out_valid     <= 1'b0;
    end else if (advance) begin
      st        <= st_next;
      count     <= count_next;
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (advance) out_beat <= res;
  end

endmodule
